FILE: rtl/core/pfs_pkg.sv
package pfs_pkg;

   localparam int MaxThreads = 64;
   localparam int PrioLevels = 32;
   localparam int TidW = $clog2(MaxThreads);
   localparam int PrioW = $clog2(PrioLevels);

   typedef logic [TidW-1:0] tid_type;
   typedef logic [PrioW-1:0] prio_type;

   localparam logic [4:0] IdlePrioReset = 5'd31;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_UNBLOCK = 3'd1,
      CMD_BLOCK = 3'd2,
      CMD_REQUEST = 3'd3,
      CMD_SCHEDULE = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK = 3'd0,
      STS_FULL = 3'd1,
      STS_NOT_BLOCKED = 3'd2,
      STS_NO_READY = 3'd3,
      STS_BAD_THREAD = 3'd4
   } status_type;

   localparam logic [1:0] ThReady = 2'd0;
   localparam logic [1:0] ThRunning = 2'd1;
   localparam logic [1:0] ThBlocked = 2'd2;

   // Controller commands to the datapath, one per step.
   typedef struct packed {
      logic latch;
      logic init;
      logic create;
      logic unblock;
      logic block;
      logic request;
      logic no_ready;
      logic demote;
      logic pop_read;
      logic pop;
      logic respond;
   } ctl_type;

   typedef struct packed {
      logic need_resched;
      logic cur_running;
      logic any_ready;
   } sts_type;

   function automatic prio_type clamp_prio(input logic [4:0] p);
      if ({27'd0, p} >= PrioLevels) begin
         return prio_type'(PrioLevels - 1);
      end
      return prio_type'(p);
   endfunction

endpackage

FILE: rtl/core/pfs_ctrl.sv
module pfs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [2:0] req_cmd,
   input  pfs_pkg::sts_type sts,
   output logic busy,
   output pfs_pkg::ctl_type ctl
);
   import pfs_pkg::*;

   typedef enum logic [7:0] {
      S_INIT = 8'b00000001,
      S_IDLE = 8'b00000010,
      S_EXEC = 8'b00000100,
      S_UNBLOCK = 8'b00001000,
      S_DEMOTE = 8'b00010000,
      S_POP_RD = 8'b00100000,
      S_POP = 8'b01000000,
      S_DONE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      ctl = '0;
      case (state_ff)
         S_INIT: begin
            ctl.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               cmd_in = req_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_CREATE: ctl.create = 1'b1;
               CMD_UNBLOCK: state_in = S_UNBLOCK;
               CMD_BLOCK: ctl.block = 1'b1;
               CMD_REQUEST: ctl.request = 1'b1;
               CMD_SCHEDULE: begin
                  if (sts.need_resched) begin
                     if (sts.cur_running) begin
                        state_in = S_DEMOTE;
                     end else if (sts.any_ready) begin
                        ctl.pop_read = 1'b1;
                        state_in = S_POP;
                     end else begin
                        ctl.no_ready = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_UNBLOCK: begin
            ctl.unblock = 1'b1;
            state_in = S_DONE;
         end
         S_DEMOTE: begin
            ctl.demote = 1'b1;
            state_in = S_POP_RD;
         end
         S_POP_RD: begin
            ctl.pop_read = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            ctl.pop = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            ctl.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule

FILE: rtl/core/pfs_datapath.sv
module pfs_datapath (
   input  logic clock,
   input  logic reset,
   input  pfs_pkg::ctl_type ctl,
   input  logic [5:0] req_thread_id,
   input  logic [4:0] req_priority_req,
   input  logic csr_wr,
   input  logic [4:0] csr_data,
   output pfs_pkg::sts_type sts,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_new_thread,
   output logic [5:0] rsp_active_thread,
   output logic [4:0] rsp_running_priority,
   output logic rsp_switched,
   output logic rsp_resched_pending
);
   import pfs_pkg::*;

   logic [MaxThreads-1:0] used_ff, used_in;
   tid_type head_ff [PrioLevels];
   tid_type head_in [PrioLevels];
   tid_type tail_ff [PrioLevels];
   tid_type tail_in [PrioLevels];
   logic [PrioLevels-1:0] ready_ff, ready_in;
   tid_type cur_ff, cur_in;
   prio_type cur_prio_ff, cur_prio_in;
   logic [1:0] cur_state_ff, cur_state_in;
   logic resched_ff, resched_in;
   tid_type tid_ff;
   prio_type preq_ff;
   logic [2:0] status_ff, status_in;
   tid_type newt_ff, newt_in;
   logic sw_ff, sw_in;
   logic valid_ff;

   prio_type prio_mem [MaxThreads];
   logic [1:0] state_mem [MaxThreads];
   tid_type link_mem [MaxThreads];
   prio_type prio_rd_ff;
   logic [1:0] state_rd_ff;
   tid_type link_rd_ff;
   tid_type rd_addr;
   logic prio_we, state_we, link_we;
   tid_type prio_wa, state_wa, link_wa;
   prio_type prio_wd;
   logic [1:0] state_wd;
   tid_type link_wd;

   tid_type free_idx, tgt, pop_t;
   logic free_found;
   prio_type lv, pop_lv;
   logic do_enq, at_head;

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = MaxThreads - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx = tid_type'(i);
         end
      end
      pop_lv = prio_type'(PrioLevels - 1);
      for (int i = PrioLevels - 1; i >= 0; i--) begin
         if (ready_ff[i]) begin
            pop_lv = prio_type'(i);
         end
      end
   end

   assign sts.need_resched = resched_ff;
   assign sts.cur_running = (cur_state_ff == ThRunning);
   assign sts.any_ready = |ready_ff;
   assign pop_t = head_ff[pop_lv];
   assign rd_addr = ctl.pop_read ? pop_t : tid_ff;

   always_comb begin
      used_in = used_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      ready_in = ready_ff;
      cur_in = cur_ff;
      cur_prio_in = cur_prio_ff;
      cur_state_in = cur_state_ff;
      resched_in = resched_ff;
      status_in = status_ff;
      newt_in = newt_ff;
      sw_in = sw_ff;
      prio_we = 1'b0;
      prio_wa = cur_ff;
      prio_wd = cur_prio_ff;
      state_we = 1'b0;
      state_wa = cur_ff;
      state_wd = ThReady;
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = cur_ff;
      do_enq = 1'b0;
      at_head = 1'b0;
      tgt = cur_ff;
      lv = cur_prio_ff;
      if (ctl.latch) begin
         status_in = STS_OK;
         newt_in = '0;
         sw_in = 1'b0;
      end
      if (ctl.init) begin
         prio_we = 1'b1;
         prio_wa = '0;
         prio_wd = cur_prio_ff;
         state_we = 1'b1;
         state_wa = '0;
         state_wd = ThRunning;
      end
      if (ctl.create) begin
         if (!free_found) begin
            status_in = STS_FULL;
         end else begin
            tgt = free_idx;
            lv = preq_ff;
            used_in[free_idx] = 1'b1;
            prio_we = 1'b1;
            prio_wa = free_idx;
            prio_wd = preq_ff;
            state_we = 1'b1;
            state_wa = free_idx;
            state_wd = ThReady;
            newt_in = free_idx;
            do_enq = 1'b1;
         end
      end
      if (ctl.unblock) begin
         if (!used_ff[tid_ff]) begin
            status_in = STS_BAD_THREAD;
         end else if (state_rd_ff != ThBlocked) begin
            status_in = STS_NOT_BLOCKED;
         end else begin
            tgt = tid_ff;
            lv = prio_rd_ff;
            state_we = 1'b1;
            state_wa = tid_ff;
            state_wd = ThReady;
            if (tid_ff == cur_ff) begin
               cur_state_in = ThReady;
            end
            do_enq = 1'b1;
            at_head = 1'b1;
         end
      end
      if (ctl.block) begin
         state_we = 1'b1;
         state_wa = cur_ff;
         state_wd = ThBlocked;
         cur_state_in = ThBlocked;
         resched_in = 1'b1;
      end
      if (ctl.request) begin
         resched_in = 1'b1;
      end
      if (ctl.no_ready) begin
         status_in = STS_NO_READY;
      end
      if (ctl.demote) begin
         tgt = cur_ff;
         lv = prio_type'(cur_prio_ff + 1'b1);
         cur_prio_in = lv;
         cur_state_in = ThReady;
         prio_we = 1'b1;
         prio_wa = cur_ff;
         prio_wd = lv;
         state_we = 1'b1;
         state_wa = cur_ff;
         state_wd = ThReady;
         do_enq = 1'b1;
      end
      if (do_enq) begin
         if (!ready_ff[lv]) begin
            head_in[lv] = tgt;
            tail_in[lv] = tgt;
         end else if (at_head) begin
            link_we = 1'b1;
            link_wa = tgt;
            link_wd = head_ff[lv];
            head_in[lv] = tgt;
         end else begin
            link_we = 1'b1;
            link_wa = tail_ff[lv];
            link_wd = tgt;
            tail_in[lv] = tgt;
         end
         ready_in[lv] = 1'b1;
         if (cur_prio_in > lv) begin
            resched_in = 1'b1;
         end
      end
      if (ctl.pop) begin
         if (pop_t == tail_ff[pop_lv]) begin
            ready_in[pop_lv] = 1'b0;
         end else begin
            head_in[pop_lv] = link_rd_ff;
         end
         cur_in = pop_t;
         cur_prio_in = prio_rd_ff;
         cur_state_in = ThRunning;
         state_we = 1'b1;
         state_wa = pop_t;
         state_wd = ThRunning;
         resched_in = 1'b0;
         sw_in = 1'b1;
      end
      if (csr_wr) begin
         prio_we = 1'b1;
         prio_wa = '0;
         prio_wd = clamp_prio(csr_data);
         if (cur_ff == '0) begin
            cur_prio_in = clamp_prio(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[prio_wa] <= prio_wd;
      end
      if (state_we) begin
         state_mem[state_wa] <= state_wd;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      prio_rd_ff <= prio_mem[rd_addr];
      state_rd_ff <= state_mem[rd_addr];
      link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= MaxThreads'(1);
         ready_ff <= '0;
         cur_ff <= '0;
         cur_prio_ff <= clamp_prio(IdlePrioReset);
         cur_state_ff <= ThRunning;
         resched_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         ready_ff <= ready_in;
         cur_ff <= cur_in;
         cur_prio_ff <= cur_prio_in;
         cur_state_ff <= cur_state_in;
         resched_ff <= resched_in;
         valid_ff <= ctl.respond;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
      status_ff <= status_in;
      newt_ff <= newt_in;
      sw_ff <= sw_in;
      if (ctl.latch) begin
         tid_ff <= req_thread_id;
         preq_ff <= clamp_prio(req_priority_req);
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_new_thread = 6'(newt_ff);
   assign rsp_active_thread = 6'(cur_ff);
   assign rsp_running_priority = 5'(cur_prio_ff);
   assign rsp_switched = sw_ff;
   assign rsp_resched_pending = resched_ff;
endmodule

FILE: rtl/core/priority_feedback_scheduler.sv
// rsp_valid is registered from the done state; unblock passes first through the unblock state,
// a schedule that only picks a thread through the pop state, and one that requeues the running
// thread through the demote, pop-read and pop states. busy holds off the next request until
// the result shows, so a new request is taken only once the last one's result is out.
// Synchronous reset empties all queues and leaves slot zero running at priority 31; busy stays
// high after reset, in the init state, while slot zero is written into the thread tables.
module priority_feedback_scheduler (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [2:0] req_cmd,
   input  logic [5:0] req_thread_id,
   input  logic [4:0] req_priority_req,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [4:0] csr_idle_priority,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_new_thread,
   output logic [5:0] rsp_active_thread,
   output logic [4:0] rsp_running_priority,
   output logic rsp_switched,
   output logic rsp_resched_pending
);
   import pfs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = !busy;

   pfs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .sts(sts), .busy(busy), .ctl(ctl)
   );

   pfs_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl),
      .req_thread_id(req_thread_id), .req_priority_req(req_priority_req),
      .csr_wr(csr_valid & csr_ready), .csr_data(csr_idle_priority), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_new_thread(rsp_new_thread),
      .rsp_active_thread(rsp_active_thread), .rsp_running_priority(rsp_running_priority),
      .rsp_switched(rsp_switched), .rsp_resched_pending(rsp_resched_pending)
   );
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import pfs_pkg::*;

   localparam int StallLimit = 2000;
   localparam logic [2:0] CmdUnknown = 3'd5;
   localparam logic [2:0] CmdUnknownHigh = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [5:0] tid;
      logic [4:0] prio;
   } sched_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] new_thread;
      logic [5:0] run_thread;
      logic [4:0] run_prio;
      logic switched;
      logic resched;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_cmd = '0;
   logic [5:0] req_thread_id = '0;
   logic [4:0] req_priority_req = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_idle_priority = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [5:0] rsp_new_thread;
   logic [5:0] rsp_active_thread;
   logic [4:0] rsp_running_priority;
   logic rsp_switched;
   logic rsp_resched_pending;

   priority_feedback_scheduler uut (.*);

   always #2 clock = ~clock;

   // Scheduler shadow state.
   logic used_q[64];
   logic [4:0] prio_q[64];
   logic [1:0] state_q[64];
   logic [5:0] link_q[64];
   logic [5:0] head_q[32];
   logic [5:0] tail_q[32];
   logic [31:0] levels_q;
   logic [5:0] cur_q;
   logic resched_q;

   sched_req_type pending_reqs[$];
   sched_rsp_type expected_rsps[$];
   int failures = 0;
   int quiet_cycles = 0;
   bit calm = 1'b0;
   int gap = 0;

   function automatic logic [4:0] sat_prio(logic [4:0] p);
      return (p >= PrioLevels) ? 5'(PrioLevels - 1) : p;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < 64; i++) begin
         used_q[i] = 1'b0;
         prio_q[i] = '0;
         state_q[i] = ThBlocked;
         link_q[i] = '0;
      end
      for (int i = 0; i < 32; i++) begin
         head_q[i] = '0;
         tail_q[i] = '0;
      end
      used_q[0] = 1'b1;
      prio_q[0] = 5'd31;
      state_q[0] = ThRunning;
      levels_q = '0;
      cur_q = '0;
      resched_q = 1'b0;
   endfunction

   function automatic void join_level(logic [5:0] t, bit at_head);
      logic [4:0] lv;
      lv = prio_q[t];
      if (!levels_q[lv]) begin
         head_q[lv] = t;
         tail_q[lv] = t;
      end else if (at_head) begin
         link_q[t] = head_q[lv];
         head_q[lv] = t;
      end else begin
         link_q[tail_q[lv]] = t;
         tail_q[lv] = t;
      end
      levels_q[lv] = 1'b1;
      if (prio_q[cur_q] > lv) resched_q = 1'b1;
   endfunction

   function automatic logic [5:0] pop_urgent();
      int lv;
      logic [5:0] t;
      lv = 0;
      while (lv < 31 && !levels_q[lv]) lv++;
      t = head_q[lv];
      if (t == tail_q[lv]) levels_q[lv] = 1'b0;
      else head_q[lv] = link_q[t];
      return t;
   endfunction

   function automatic sched_rsp_type predict_sched(sched_req_type r);
      sched_rsp_type o;
      int i;
      o = '0;
      case (r.cmd)
         CMD_CREATE: begin
            i = 0;
            while (i < 64 && used_q[i]) i++;
            if (i >= 64) begin
               o.status = STS_FULL;
            end else begin
               used_q[i] = 1'b1;
               prio_q[i] = sat_prio(r.prio);
               state_q[i] = ThReady;
               join_level(6'(i), 1'b0);
               o.new_thread = 6'(i);
            end
         end
         CMD_UNBLOCK: begin
            if (!used_q[r.tid]) o.status = STS_BAD_THREAD;
            else if (state_q[r.tid] != ThBlocked) o.status = STS_NOT_BLOCKED;
            else begin
               state_q[r.tid] = ThReady;
               join_level(r.tid, 1'b1);
            end
         end
         CMD_BLOCK: begin
            state_q[cur_q] = ThBlocked;
            resched_q = 1'b1;
         end
         CMD_REQUEST: resched_q = 1'b1;
         CMD_SCHEDULE: begin
            if (resched_q) begin
               if (state_q[cur_q] != ThRunning && levels_q == 0) begin
                  o.status = STS_NO_READY;
               end else begin
                  resched_q = 1'b0;
                  if (state_q[cur_q] == ThRunning) begin
                     prio_q[cur_q] = prio_q[cur_q] + 5'd1;
                     state_q[cur_q] = ThReady;
                     join_level(cur_q, 1'b0);
                  end
                  cur_q = pop_urgent();
                  state_q[cur_q] = ThRunning;
                  o.switched = 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.run_thread = cur_q;
      o.run_prio = prio_q[cur_q];
      o.resched = resched_q;
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_sched(pending_reqs.pop_front()));
            quiet_cycles <= 0;
         end else if (rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (!(start && busy)) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0 && !(start && !busy && pending_reqs.size() == 0)) begin
               if (!calm && $urandom_range(0, 5) == 0) begin
                  gap = $urandom_range(0, 10);
                  start <= 1'b0;
               end else begin
                  start <= 1'b1;
                  req_cmd <= pending_reqs[0].cmd;
                  req_thread_id <= pending_reqs[0].tid;
                  req_priority_req <= pending_reqs[0].prio;
               end
            end else start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      sched_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response");
            failures++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_status);
               failures++;
            end
            if (rsp_new_thread !== exp_rsp.new_thread) begin
               $error("new_thread exp %0d got %0d", exp_rsp.new_thread, rsp_new_thread);
               failures++;
            end
            if (rsp_active_thread !== exp_rsp.run_thread) begin
               $error("active_thread exp %0d got %0d", exp_rsp.run_thread,
                      rsp_active_thread);
               failures++;
            end
            if (rsp_running_priority !== exp_rsp.run_prio) begin
               $error("running_priority exp %0d got %0d", exp_rsp.run_prio,
                      rsp_running_priority);
               failures++;
            end
            if (rsp_switched !== exp_rsp.switched) begin
               $error("switched exp %0d got %0d", exp_rsp.switched, rsp_switched);
               failures++;
            end
            if (rsp_resched_pending !== exp_rsp.resched) begin
               $error("resched_pending exp %0d got %0d", exp_rsp.resched,
                      rsp_resched_pending);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= StallLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic sched_req_type mk_req(logic [2:0] c, logic [5:0] t, logic [4:0] p);
      sched_req_type r;
      r.cmd = c;
      r.tid = t;
      r.prio = p;
      return r;
   endfunction

   function automatic sched_req_type rand_req();
      int pick;
      logic [2:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 30) c = CMD_CREATE;
      else if (pick < 45) c = CMD_UNBLOCK;
      else if (pick < 60) c = CMD_BLOCK;
      else if (pick < 70) c = CMD_REQUEST;
      else if (pick < 97) c = CMD_SCHEDULE;
      else c = 3'($urandom_range(CmdUnknown, CmdUnknownHigh));
      return mk_req(c, 6'($urandom_range(0, 63)),
                    ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7)));
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_idle_prio(logic [4:0] v);
      csr_valid <= 1'b1;
      csr_idle_priority <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      prio_q[0] = sat_prio(v);
   endtask

   initial begin
      shadow_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every command, the error cases other than a full table.
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_UNBLOCK, 6'd63, 5'd0));
      pending_reqs.push_back(mk_req(CMD_UNBLOCK, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_CREATE, 6'd63, 5'd31));
      pending_reqs.push_back(mk_req(CMD_CREATE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_UNBLOCK, 6'd1, 5'd0));
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_BLOCK, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_BLOCK, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_REQUEST, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_BLOCK, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_BLOCK, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_UNBLOCK, 6'd2, 5'd0));
      pending_reqs.push_back(mk_req(CmdUnknown, 6'h2a, 5'h15));
      pending_reqs.push_back(mk_req(CmdUnknownHigh, 6'h15, 5'h0a));
      drain();

      write_idle_prio(5'd0);
      for (int i = 0; i < 70; i++) pending_reqs.push_back(mk_req(CMD_CREATE, 6'(i), 5'(i)));
      pending_reqs.push_back(mk_req(CMD_REQUEST, 6'd0, 5'd0));
      pending_reqs.push_back(mk_req(CMD_SCHEDULE, 6'd0, 5'd0));
      drain();

      write_idle_prio(5'd31);
      for (int i = 0; i < 200; i++) pending_reqs.push_back(rand_req());
      drain();

      write_idle_prio(5'($urandom_range(1, 30)));
      for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());
      drain();

      calm = 1'b1;
      for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
      drain();

      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
